[hdl/integer_field_formatter_top_defines.svh]
// Assertion macros shared by the integer field formatter RTL.
`ifndef INTEGER_FIELD_FORMATTER_TOP_DEFINES_SVH
`define INTEGER_FIELD_FORMATTER_TOP_DEFINES_SVH
`ifndef NO_ASSERTIONS
// Property checked on every clock edge while out of reset.
`define IFF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// Antecedent in this cycle implies the consequent in the next cycle.
`define IFF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) else $error(msg);
`else
`define IFF_ASSERT(lbl, prop, msg)
`define IFF_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

[hdl/iff_pkg.sv]
// Types, codes and character tables of the integer field formatter.
`default_nettype none
package iff_pkg;

  typedef enum logic [2:0] {
    MODE_SDEC = 3'd0,
    MODE_UDEC = 3'd1,
    MODE_HEXL = 3'd2,
    MODE_HEXU = 3'd3,
    MODE_OCT  = 3'd4,
    MODE_BIN  = 3'd5,
    MODE_PTR  = 3'd6,
    MODE_CHAR = 3'd7
  } mode_e;

  // Bit positions in the flag field.
  localparam int FL_LEFT  = 0;
  localparam int FL_PLUS  = 1;
  localparam int FL_SPACE = 2;
  localparam int FL_ZERO  = 3;
  localparam int FL_ALT   = 4;

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_LX    = 8'h78;
  localparam logic [7:0] CH_UX    = 8'h58;

  // Digit count used by pointer conversions when no precision is given.
  localparam logic [5:0] PTR_PREC = 6'd8;

  localparam logic [127:0] LOWER_DIGITS = "0123456789abcdef";
  localparam logic [127:0] UPPER_DIGITS = "0123456789ABCDEF";

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CONV,
    ST_COUNT,
    ST_LAYOUT,
    ST_EMIT
  } state_e;

  typedef struct packed {
    logic load;
    logic conv_step;
    logic count_step;
    logic layout;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic is_dec;
    logic conv_done;
    logic count_done;
    logic empty;
    logic out_free;
    logic emit_last;
  } sts_t;

  function automatic logic [7:0] digit_char(input logic [3:0] d, input logic upper);
    logic [6:0] base;
    base = {3'd0, 4'd15 - d} << 3;
    if (upper) begin
      return UPPER_DIGITS[base +: 8];
    end
    return LOWER_DIGITS[base +: 8];
  endfunction

endpackage
`default_nettype wire

[hdl/iff_req_if.sv]
// Request channel: one conversion request per transfer.
`default_nettype none
interface iff_req_if #(parameter int VALUE_BITS = 32);
  logic                  valid;
  logic                  ready;
  logic [2:0]            mode;
  logic [VALUE_BITS-1:0] value;
  logic [4:0]            flag_bits;
  logic [6:0]            field_width;
  logic signed [6:0]     digit_precision;

  modport source(output valid, mode, value, flag_bits, field_width, digit_precision,
                 input ready);
  modport sink(input valid, mode, value, flag_bits, field_width, digit_precision,
               output ready);
endinterface
`default_nettype wire

[hdl/iff_chr_if.sv]
// Character channel: one output character per transfer.
`default_nettype none
interface iff_chr_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_out;
  logic       last_char;

  modport source(output valid, char_out, last_char, input ready);
  modport sink(input valid, char_out, last_char, output ready);
endinterface
`default_nettype wire

[hdl/iff_ctrl.sv]
// Controller state machine that sequences one conversion request.
`default_nettype none
module iff_ctrl (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         in_valid_i,
  output logic              in_ready_o,
  output iff_pkg::cmd_t     cmd_o,
  input  wire iff_pkg::sts_t sts_i
);

  iff_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= iff_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      iff_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = iff_pkg::ST_CONV;
        end
      end
      iff_pkg::ST_CONV: begin
        // Only decimal modes need the binary to BCD pass.
        if (!sts_i.is_dec) begin
          state_d = iff_pkg::ST_COUNT;
        end else begin
          cmd_o.conv_step = 1'b1;
          if (sts_i.conv_done) begin
            state_d = iff_pkg::ST_COUNT;
          end
        end
      end
      iff_pkg::ST_COUNT: begin
        cmd_o.count_step = 1'b1;
        if (sts_i.count_done) begin
          state_d = iff_pkg::ST_LAYOUT;
        end
      end
      iff_pkg::ST_LAYOUT: begin
        cmd_o.layout = 1'b1;
        state_d      = iff_pkg::ST_EMIT;
      end
      iff_pkg::ST_EMIT: begin
        if (sts_i.empty) begin
          state_d = iff_pkg::ST_IDLE;
        end else if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          if (sts_i.emit_last) begin
            state_d = iff_pkg::ST_IDLE;
          end
        end
      end
      default: begin
        state_d = iff_pkg::ST_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

[hdl/iff_dp.sv]
// Datapath: request registers, BCD conversion, digit count, layout and output stage.
`default_nettype none
module iff_dp #(
  parameter int VALUE_BITS = 32,
  parameter int MAX_FIELD  = 64
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire iff_pkg::cmd_t         cmd_i,
  output iff_pkg::sts_t              sts_o,
  input  wire logic [2:0]            mode_i,
  input  wire logic [VALUE_BITS-1:0] value_i,
  input  wire logic [4:0]            flag_bits_i,
  input  wire logic [6:0]            field_width_i,
  input  wire logic signed [6:0]     digit_precision_i,
  output logic [7:0]                 char_out_o,
  output logic                       last_char_o,
  output logic                       out_valid_o,
  input  wire logic                  out_ready_i
);

  localparam int NDEC = ((VALUE_BITS * 1233) >> 12) + 1;
  localparam int BW   = 4 * NDEC;
  localparam int WW   = (BW > VALUE_BITS + 3) ? BW : VALUE_BITS + 3;
  localparam int CW   = $clog2(VALUE_BITS);
  localparam int NW   = $clog2(MAX_FIELD + 1);

  // Request registers.
  iff_pkg::mode_e        mode_q;
  logic                  is_dec_q, upper_q, left_q, zpad_q, pgiven_q, kill_q;
  logic [5:0]            prec_q;
  logic [6:0]            width_q;
  logic [1:0]            plen_q;
  logic [7:0]            pfx0_q, pfx1_q;
  logic [VALUE_BITS-1:0] sh_q;
  logic [WW-1:0]         w_q, cw_q;
  logic [CW-1:0]         cnt_q;
  logic [6:0]            dlen_q;

  // Layout registers.
  logic [7:0]    s1_q, s2_q, s3_q, s4_q;
  logic [NW-1:0] totc_q, n_q;

  // Output stage.
  logic       out_valid_q, out_valid_d;
  logic [7:0] char_q;
  logic       last_q;

  // Load decode.
  logic                  neg, vnz, given, kill, zpad;
  logic [VALUE_BITS-1:0] vabs;
  logic [5:0]            pval;
  logic [1:0]            plen;
  logic [7:0]            pfx0, pfx1;
  iff_pkg::mode_e        mode_in;

  always_comb begin
    mode_in = iff_pkg::mode_e'(mode_i);
    neg     = (mode_in == iff_pkg::MODE_SDEC) && value_i[VALUE_BITS-1];
    vabs    = neg ? (~value_i + 1'b1) : value_i;
    vnz     = |value_i;
    given   = !digit_precision_i[6];
    pval    = digit_precision_i[5:0];
    plen    = 2'd0;
    pfx0    = iff_pkg::CH_ZERO;
    pfx1    = iff_pkg::CH_LX;
    case (mode_in)
      iff_pkg::MODE_SDEC: begin
        if (neg) begin
          pfx0 = iff_pkg::CH_MINUS;
          plen = 2'd1;
        end else if (flag_bits_i[iff_pkg::FL_PLUS]) begin
          pfx0 = iff_pkg::CH_PLUS;
          plen = 2'd1;
        end else if (flag_bits_i[iff_pkg::FL_SPACE]) begin
          pfx0 = iff_pkg::CH_SPACE;
          plen = 2'd1;
        end
      end
      iff_pkg::MODE_HEXL: begin
        if (flag_bits_i[iff_pkg::FL_ALT] && vnz) begin
          plen = 2'd2;
        end
      end
      iff_pkg::MODE_HEXU: begin
        pfx1 = iff_pkg::CH_UX;
        if (flag_bits_i[iff_pkg::FL_ALT] && vnz) begin
          plen = 2'd2;
        end
      end
      iff_pkg::MODE_OCT: begin
        if (flag_bits_i[iff_pkg::FL_ALT] && vnz) begin
          plen = 2'd1;
        end
      end
      iff_pkg::MODE_PTR: begin
        plen = 2'd2;
        if (!given) begin
          given = 1'b1;
          pval  = iff_pkg::PTR_PREC;
        end
      end
      iff_pkg::MODE_CHAR: begin
        given = 1'b0;
      end
      default: begin
      end
    endcase
    kill = (mode_in != iff_pkg::MODE_PTR) && (mode_in != iff_pkg::MODE_CHAR) &&
           given && (pval == 6'd0) && !vnz;
    zpad = flag_bits_i[iff_pkg::FL_ZERO] && !flag_bits_i[iff_pkg::FL_LEFT] && !given &&
           (mode_in != iff_pkg::MODE_CHAR);
  end

  // Digit width per mode: binary 1 bit, octal 3 bits, else 4 bits (hex or BCD).
  logic is_bin, is_oct, is_char;
  assign is_bin  = (mode_q == iff_pkg::MODE_BIN);
  assign is_oct  = (mode_q == iff_pkg::MODE_OCT);
  assign is_char = (mode_q == iff_pkg::MODE_CHAR);

  // Double-dabble step: add 3 to each BCD digit of five or more, then shift in one bit.
  logic [BW-1:0] adj;
  logic [BW-1:0] bcd_nx;
  always_comb begin
    for (int i = 0; i < NDEC; i++) begin
      adj[4*i +: 4] = (w_q[4*i +: 4] >= 4'd5) ? (w_q[4*i +: 4] + 4'd3) : w_q[4*i +: 4];
    end
    bcd_nx = {adj[BW-2:0], sh_q[VALUE_BITS-1]};
  end

  logic [WW-1:0] cw_sh;
  always_comb begin
    if (is_bin) begin
      cw_sh = cw_q >> 1;
    end else if (is_oct) begin
      cw_sh = cw_q >> 3;
    end else begin
      cw_sh = cw_q >> 4;
    end
  end

  // Layout of the field from the digit count.
  logic [6:0]    dlen_e, zeros;
  logic [7:0]    body, w8, pad, tot, s1, s2, s3, s4;
  logic [NW-1:0] totc;
  always_comb begin
    dlen_e = is_char ? 7'd1 : (kill_q ? 7'd0 : dlen_q);
    zeros  = (pgiven_q && ({1'b0, prec_q} > dlen_e)) ? ({1'b0, prec_q} - dlen_e) : 7'd0;
    body   = {6'd0, plen_q} + {1'b0, zeros} + {1'b0, dlen_e};
    w8     = {1'b0, width_q};
    pad    = (w8 > body) ? (w8 - body) : 8'd0;
    tot    = (w8 > body) ? w8 : body;
    totc   = (tot > 8'(MAX_FIELD)) ? NW'(MAX_FIELD) : tot[NW-1:0];
    s1     = (!zpad_q && !left_q) ? pad : 8'd0;
    s2     = s1 + {6'd0, plen_q};
    s3     = s2 + (zpad_q ? (pad + {1'b0, zeros}) : {1'b0, zeros});
    s4     = s3 + {1'b0, dlen_e};
  end

  // Character at the current output position.
  logic [7:0]    n8, di, dch, ch;
  logic [9:0]    sa;
  logic [WW-1:0] wsh;
  logic [3:0]    d4;
  logic          last;
  always_comb begin
    n8  = 8'(n_q);
    di  = s4_q - 8'd1 - n8;
    if (is_bin) begin
      sa = {2'd0, di};
    end else if (is_oct) begin
      sa = {2'd0, di} + {1'b0, di, 1'b0};
    end else begin
      sa = {di, 2'd0};
    end
    wsh = w_q >> sa;
    if (is_bin) begin
      d4 = {3'd0, wsh[0]};
    end else if (is_oct) begin
      d4 = {1'b0, wsh[2:0]};
    end else begin
      d4 = wsh[3:0];
    end
    dch = is_char ? w_q[7:0] : iff_pkg::digit_char(d4, upper_q);
    if (n8 < s1_q) begin
      ch = iff_pkg::CH_SPACE;
    end else if (n8 < s2_q) begin
      ch = (n8 == s1_q) ? pfx0_q : pfx1_q;
    end else if (n8 < s3_q) begin
      ch = iff_pkg::CH_ZERO;
    end else if (n8 < s4_q) begin
      ch = dch;
    end else begin
      ch = iff_pkg::CH_SPACE;
    end
    last = (n_q == totc_q - 1'b1);
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      mode_q   <= mode_in;
      is_dec_q <= (mode_in == iff_pkg::MODE_SDEC) || (mode_in == iff_pkg::MODE_UDEC);
      upper_q  <= (mode_in == iff_pkg::MODE_HEXU);
      left_q   <= flag_bits_i[iff_pkg::FL_LEFT];
      zpad_q   <= zpad;
      pgiven_q <= given;
      prec_q   <= pval;
      kill_q   <= kill;
      width_q  <= field_width_i;
      plen_q   <= plen;
      pfx0_q   <= pfx0;
      pfx1_q   <= pfx1;
      sh_q     <= vabs;
      cnt_q    <= '0;
      dlen_q   <= 7'd0;
      if ((mode_in == iff_pkg::MODE_SDEC) || (mode_in == iff_pkg::MODE_UDEC)) begin
        w_q  <= '0;
        cw_q <= '0;
      end else begin
        w_q  <= WW'(vabs);
        cw_q <= WW'(vabs);
      end
    end
    if (cmd_i.conv_step) begin
      w_q   <= WW'(bcd_nx);
      cw_q  <= WW'(bcd_nx);
      sh_q  <= sh_q << 1;
      cnt_q <= cnt_q + 1'b1;
    end
    if (cmd_i.count_step) begin
      cw_q   <= cw_sh;
      dlen_q <= dlen_q + 7'd1;
    end
    if (cmd_i.layout) begin
      s1_q   <= s1;
      s2_q   <= s2;
      s3_q   <= s3;
      s4_q   <= s4;
      totc_q <= totc;
      n_q    <= '0;
    end
    if (cmd_i.emit) begin
      n_q    <= n_q + 1'b1;
      char_q <= ch;
      last_q <= last;
    end
  end

  assign out_valid_d = cmd_i.emit | (out_valid_q & ~out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    sts_o.is_dec     = is_dec_q;
    sts_o.conv_done  = (cnt_q == CW'(VALUE_BITS - 1));
    sts_o.count_done = (cw_sh == '0);
    sts_o.empty      = (totc_q == '0);
    sts_o.out_free   = !out_valid_q || out_ready_i;
    sts_o.emit_last  = last;
  end

  assign char_out_o  = char_q;
  assign last_char_o = last_q;
  assign out_valid_o = out_valid_q;

endmodule
`default_nettype wire

[hdl/integer_field_formatter_top.sv]
// Top level of the integer field formatter: controller, datapath and assertions.
//
// The block takes one printf-style integer conversion request per transfer on req_i and
// sends the characters of the formatted field on chr_o, one per transfer, with last_char
// set on the final one. Requests are handled one at a time. A request is first captured.
// It then goes through the bit-serial binary to BCD converter when the mode is signed or
// unsigned decimal, and passes straight on otherwise. After that come the digit counter
// and the layout step. Finally the characters are emitted, each while the output register
// is free or chr_o is ready, or the request ends there when the field is empty.
// A request that produces no characters gives no transfer on chr_o. At most MAX_FIELD
// characters are sent per request; the last of them is marked. The output register lets
// the next request be accepted while the final character of the previous one still waits.
`default_nettype none
`include "integer_field_formatter_top_defines.svh"
module integer_field_formatter_top #(
  parameter int VALUE_BITS = 32,
  parameter int MAX_FIELD  = 64
) (
  input wire logic  clk_i,
  input wire logic  rst_ni,
  iff_req_if.sink   req_i,
  iff_chr_if.source chr_o
);

  iff_pkg::cmd_t cmd;
  iff_pkg::sts_t sts;

  // The controller owns the request handshake; the datapath owns the output register.
  iff_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (req_i.valid),
    .in_ready_o (req_i.ready),
    .cmd_o      (cmd),
    .sts_i      (sts)
  );

  iff_dp #(
    .VALUE_BITS (VALUE_BITS),
    .MAX_FIELD  (MAX_FIELD)
  ) u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .sts_o             (sts),
    .mode_i            (req_i.mode),
    .value_i           (req_i.value),
    .flag_bits_i       (req_i.flag_bits),
    .field_width_i     (req_i.field_width),
    .digit_precision_i (req_i.digit_precision),
    .char_out_o        (chr_o.char_out),
    .last_char_o       (chr_o.last_char),
    .out_valid_o       (chr_o.valid),
    .out_ready_i       (chr_o.ready)
  );

  // No character is produced while a new request may be taken.
  `IFF_ASSERT(a_no_emit_when_ready, !(req_i.ready && cmd.emit), "emit while ready for a request")
  // A character is only loaded when the output register is free.
  `IFF_ASSERT(a_emit_needs_slot, (!cmd.emit || sts.out_free), "emit overwrote a pending character")
  // After a request transfer the block is busy.
  `IFF_ASSERT_NEXT(a_busy_after_load, req_i.valid && req_i.ready, !req_i.ready, "ready after load")
  // Loading the final character returns the block to accepting requests.
  `IFF_ASSERT_NEXT(a_ready_after_last, cmd.emit && sts.emit_last, req_i.ready, "not ready after last")

endmodule
`default_nettype wire

[verif/tb_integer_field_formatter_top.sv]
`timescale 1ns / 1ps
// Self-checking testbench for the integer field formatter top level.
module tb_integer_field_formatter_top;

  // Run shape. The cycle limit assumes the slowest legal run: every request
  // produces 64 characters, every character waits out the longest stall and
  // every request sits behind the longest gap plus the decimal conversion.
  // The limit covers that worst case several times over.
  localparam int MAX_CHARS       = 64;
  localparam int CYCLE_LIMIT     = 2_000_000;
  localparam int RANDOM_ITEMS    = 355;
  localparam int CALM_ITEMS      = 50;
  localparam int SEGMENT_ITEMS   = 40;
  localparam int HOLD_OFF_CYCLES = 400;
  // A decimal request that produces no characters still goes through the
  // whole decimal conversion, so the drain covers several of those.
  localparam int DRAIN_CYCLES    = 150;

  localparam logic [7:0] CH_LOWER_A = 8'h61;
  localparam logic [7:0] CH_UPPER_A = 8'h41;

  // Flag masks built from the bit positions in the package.
  localparam logic [4:0] F_NONE  = 5'b0;
  localparam logic [4:0] F_LEFT  = 5'b1 << iff_pkg::FL_LEFT;
  localparam logic [4:0] F_PLUS  = 5'b1 << iff_pkg::FL_PLUS;
  localparam logic [4:0] F_SPACE = 5'b1 << iff_pkg::FL_SPACE;
  localparam logic [4:0] F_ZERO  = 5'b1 << iff_pkg::FL_ZERO;
  localparam logic [4:0] F_ALT   = 5'b1 << iff_pkg::FL_ALT;

  typedef struct {
    iff_pkg::mode_e    mode;
    logic [31:0]       value;
    logic [4:0]        flag_bits;
    logic [6:0]        field_width;
    logic signed [6:0] digit_precision;
  } conv_req_t;

  typedef struct {
    logic [7:0] char_out;
    logic       last_char;
  } field_char_t;

  // Holds the characters that accepted requests must still produce, in order,
  // and compares each character transfer against the oldest of them.
  class field_char_checker;
    field_char_t pending_chars[$];
    int          mismatches;

    task report_mismatch(string msg);
      $display("MISMATCH at %0t ns: %s", $time, msg);
      mismatches++;
    endtask

    // Works out the formatted field of one request and queues its characters.
    function void add_request_field(conv_req_t r);
      logic [7:0]  field[$];
      logic [7:0]  prefix[$];
      logic [7:0]  digits[$];
      logic [63:0] mag;
      logic [31:0] neg_value;
      logic [3:0]  d;
      int          base, prec, width, zeros, body, pad, count;
      bit          left, upper, keep_zero, zero_fill;

      left  = r.flag_bits[iff_pkg::FL_LEFT];
      width = int'(r.field_width);
      prec  = int'(r.digit_precision);

      if (r.mode == iff_pkg::MODE_CHAR) begin
        pad = (width > 1) ? width - 1 : 0;
        if (!left) repeat (pad) field.push_back(iff_pkg::CH_SPACE);
        field.push_back(r.value[7:0]);
        if (left) repeat (pad) field.push_back(iff_pkg::CH_SPACE);
      end else begin
        mag       = {32'h0, r.value};
        base      = 10;
        upper     = 1'b0;
        keep_zero = 1'b0;
        case (r.mode)
          iff_pkg::MODE_SDEC: begin
            if (r.value[31]) begin
              neg_value = 32'd0 - r.value;
              mag       = {32'h0, neg_value};
              prefix.push_back(iff_pkg::CH_MINUS);
            end else if (r.flag_bits[iff_pkg::FL_PLUS]) begin
              prefix.push_back(iff_pkg::CH_PLUS);
            end else if (r.flag_bits[iff_pkg::FL_SPACE]) begin
              prefix.push_back(iff_pkg::CH_SPACE);
            end
          end
          iff_pkg::MODE_HEXL, iff_pkg::MODE_HEXU: begin
            base  = 16;
            upper = (r.mode == iff_pkg::MODE_HEXU);
            if (r.flag_bits[iff_pkg::FL_ALT] && r.value != 0) begin
              prefix.push_back(iff_pkg::CH_ZERO);
              prefix.push_back(upper ? iff_pkg::CH_UX : iff_pkg::CH_LX);
            end
          end
          iff_pkg::MODE_OCT: begin
            base = 8;
            if (r.flag_bits[iff_pkg::FL_ALT] && r.value != 0) begin
              prefix.push_back(iff_pkg::CH_ZERO);
            end
          end
          iff_pkg::MODE_BIN: begin
            base = 2;
          end
          iff_pkg::MODE_PTR: begin
            base      = 16;
            keep_zero = 1'b1;
            prefix.push_back(iff_pkg::CH_ZERO);
            prefix.push_back(iff_pkg::CH_LX);
            if (prec < 0) prec = int'(iff_pkg::PTR_PREC);
          end
          default: begin
          end
        endcase

        // Digits come out least significant first, so build the string from the front.
        do begin
          d = 4'(mag % 64'(base));
          digits.push_front((d < 10) ? iff_pkg::CH_ZERO + 8'(d)
                                     : (upper ? CH_UPPER_A : CH_LOWER_A) + 8'(d) - 8'd10);
          mag = mag / 64'(base);
        end while (mag != 0);
        // A zero value with zero precision has no digits at all, except for pointers.
        if (!keep_zero && prec == 0 && r.value == 0) digits.delete();

        zeros     = (prec > digits.size()) ? prec - digits.size() : 0;
        body      = prefix.size() + zeros + digits.size();
        pad       = (width > body) ? width - body : 0;
        zero_fill = r.flag_bits[iff_pkg::FL_ZERO] && !left && prec < 0;

        if (!zero_fill && !left) repeat (pad) field.push_back(iff_pkg::CH_SPACE);
        foreach (prefix[i]) field.push_back(prefix[i]);
        repeat (zero_fill ? pad + zeros : zeros) field.push_back(iff_pkg::CH_ZERO);
        foreach (digits[i]) field.push_back(digits[i]);
        if (!zero_fill && left) repeat (pad) field.push_back(iff_pkg::CH_SPACE);
      end

      // Overlong fields are cut at the maximum, and the cut-off point is marked last.
      count = (field.size() < MAX_CHARS) ? field.size() : MAX_CHARS;
      for (int i = 0; i < count; i++) begin
        pending_chars.push_back('{char_out: field[i], last_char: (i == count - 1)});
      end
    endfunction

    task check_char(logic [7:0] got_char, logic got_last);
      field_char_t want;
      if (pending_chars.size() == 0) begin
        report_mismatch($sformatf("character 0x%02h arrived with nothing outstanding",
                                  got_char));
      end else begin
        want = pending_chars.pop_front();
        if (got_char !== want.char_out) begin
          report_mismatch($sformatf("char_out 0x%02h, wanted 0x%02h", got_char,
                                    want.char_out));
        end
        if (got_last !== want.last_char) begin
          report_mismatch($sformatf("last_char %0b on char 0x%02h, wanted %0b", got_last,
                                    want.char_out, want.last_char));
        end
      end
    endtask
  endclass

  logic clk_i;
  logic rst_ni;

  iff_req_if #(.VALUE_BITS(32)) req_bus ();
  iff_chr_if chr_bus ();

  integer_field_formatter_top #(
    .VALUE_BITS(32),
    .MAX_FIELD (MAX_CHARS)
  ) uut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_bus.sink),
    .chr_o (chr_bus.source)
  );

  field_char_checker char_board = new();

  // Idling odds shared by both sides: zero turns idling off, a larger value
  // makes bursts rarer. The main process changes it per stretch of requests.
  int idle_odds   = 3;
  // Remaining cycles of the long receiver hold-off; set once by the main
  // process and counted down by the receiver.
  int hold_left   = 0;
  int cycle_count = 0;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL integer_field_formatter_top");
      $finish;
    end
  end

  function automatic conv_req_t make_request(iff_pkg::mode_e m, logic [31:0] v,
                                             logic [4:0] f, int w, int p);
    conv_req_t r;
    r.mode            = m;
    r.value           = v;
    r.flag_bits       = f;
    r.field_width     = 7'(w);
    r.digit_precision = 7'(p);
    return r;
  endfunction

  // Random requests lean toward small widths and precisions so that most
  // fields are short, with a tail of long and overlong ones. Precision is
  // often absent, sometimes another negative value.
  function automatic conv_req_t random_request();
    logic [31:0] v;
    int          w, p, pick;

    pick = $urandom_range(0, 9);
    if (pick < 2) begin
      v = $urandom_range(0, 20);
    end else if (pick == 2) begin
      case ($urandom_range(0, 4))
        0: v = 32'h0000_0000;
        1: v = 32'h8000_0000;
        2: v = 32'hFFFF_FFFF;
        3: v = 32'h7FFF_FFFF;
        default: v = 32'h1 << $urandom_range(0, 31);
      endcase
    end else begin
      v = $urandom;
    end

    pick = $urandom_range(0, 9);
    if (pick < 7) w = $urandom_range(0, 20);
    else if (pick < 9) w = $urandom_range(21, 64);
    else w = $urandom_range(65, 127);

    pick = $urandom_range(0, 19);
    if (pick < 8) p = -1;
    else if (pick < 11) p = -int'($urandom_range(2, 64));
    else if (pick < 18) p = $urandom_range(0, 20);
    else p = $urandom_range(21, 63);

    return make_request(iff_pkg::mode_e'($urandom_range(0, 7)), v,
                        5'($urandom_range(0, 31)), w, p);
  endfunction

  // Offers one request, after an optional idle burst, and holds it until the
  // transfer completes. Valid stays high between back-to-back requests, so
  // it only gets one assignment per edge.
  task automatic send_request(input conv_req_t r);
    int gap;
    gap = 0;
    if (idle_odds > 0 && $urandom_range(0, idle_odds - 1) == 0) gap = $urandom_range(1, 11);
    if (gap > 0) begin
      req_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_bus.valid           <= 1'b1;
    req_bus.mode            <= r.mode;
    req_bus.value           <= r.value;
    req_bus.flag_bits       <= r.flag_bits;
    req_bus.field_width     <= r.field_width;
    req_bus.digit_precision <= r.digit_precision;
    do @(posedge clk_i); while (req_bus.ready !== 1'b1);
    char_board.add_request_field(r);
  endtask

  // Receiver: samples each character transfer at the edge, then decides
  // ready for the next cycle. The long hold-off takes priority, then any
  // running stall burst, then a chance of starting a new burst.
  initial begin
    int stall_left;
    stall_left    = 0;
    chr_bus.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (chr_bus.valid === 1'b1 && chr_bus.ready === 1'b1) begin
        char_board.check_char(chr_bus.char_out, chr_bus.last_char);
      end
      if (hold_left > 0) begin
        hold_left--;
        chr_bus.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        chr_bus.ready <= 1'b0;
      end else if (idle_odds > 0 && $urandom_range(0, 2 * idle_odds) == 0) begin
        stall_left    = $urandom_range(0, 10);
        chr_bus.ready <= 1'b0;
      end else begin
        chr_bus.ready <= 1'b1;
      end
    end
  end

  initial begin
    rst_ni                  <= 1'b0;
    req_bus.valid           <= 1'b0;
    req_bus.mode            <= iff_pkg::MODE_SDEC;
    req_bus.value           <= '0;
    req_bus.flag_bits       <= '0;
    req_bus.field_width     <= '0;
    req_bus.digit_precision <= '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed requests: sign handling, flag precedence, padding layouts,
    // alternate prefixes on zero and nonzero values, pointer defaults, the
    // character mode with flags it must ignore, empty fields and fields
    // that run past the maximum length.
    send_request(make_request(iff_pkg::MODE_SDEC, 32'h0000_0000, F_NONE, 0, -1));
    send_request(make_request(iff_pkg::MODE_SDEC, 32'h8000_0000, F_NONE, 0, -1));
    send_request(make_request(iff_pkg::MODE_SDEC, 32'h7FFF_FFFF, F_PLUS, 0, -1));
    send_request(make_request(iff_pkg::MODE_SDEC, 32'd5, F_SPACE, 4, -1));
    send_request(make_request(iff_pkg::MODE_SDEC, 32'd5, F_PLUS | F_SPACE, 0, -1));
    send_request(make_request(iff_pkg::MODE_SDEC, 32'hFFFF_FFD6, F_ZERO, 10, -1));
    send_request(make_request(iff_pkg::MODE_SDEC, 32'hFFFF_FFF9, F_LEFT | F_ZERO, 8, -1));
    send_request(make_request(iff_pkg::MODE_UDEC, 32'hFFFF_FFFF, F_NONE, 0, -1));
    send_request(make_request(iff_pkg::MODE_UDEC, 32'd123, F_ZERO, 20, 10));
    send_request(make_request(iff_pkg::MODE_UDEC, 32'h0000_0000, F_NONE, 0, 0));
    send_request(make_request(iff_pkg::MODE_SDEC, 32'h0000_0000, F_PLUS, 0, 0));
    send_request(make_request(iff_pkg::MODE_HEXL, 32'hDEAD_BEEF, F_ALT, 0, -1));
    send_request(make_request(iff_pkg::MODE_HEXU, 32'h00AB_CDEF, F_ALT | F_ZERO, 12, -1));
    send_request(make_request(iff_pkg::MODE_HEXL, 32'h0000_0000, F_ALT, 0, 0));
    send_request(make_request(iff_pkg::MODE_HEXL, 32'h0000_0000, F_ALT, 3, -1));
    send_request(make_request(iff_pkg::MODE_OCT, 32'd8, F_ALT, 0, -1));
    send_request(make_request(iff_pkg::MODE_OCT, 32'h0000_0000, F_ALT, 0, -1));
    send_request(make_request(iff_pkg::MODE_BIN, 32'hFFFF_FFFF, F_LEFT, 40, -1));
    send_request(make_request(iff_pkg::MODE_PTR, 32'h0000_0000, F_NONE, 0, -1));
    send_request(make_request(iff_pkg::MODE_PTR, 32'h0000_1234, F_ALT | F_ZERO, 12, 0));
    send_request(make_request(iff_pkg::MODE_PTR, 32'h0000_0000, F_LEFT, 5, 0));
    send_request(make_request(iff_pkg::MODE_CHAR, 32'h0000_0041, F_LEFT, 5, -1));
    send_request(make_request(iff_pkg::MODE_CHAR, 32'hFFFF_FFFF,
                              F_PLUS | F_SPACE | F_ZERO | F_ALT, 3, 20));
    send_request(make_request(iff_pkg::MODE_CHAR, 32'h0000_0000, F_NONE, 0, 0));
    send_request(make_request(iff_pkg::MODE_UDEC, 32'd1, F_NONE, 127, -1));
    send_request(make_request(iff_pkg::MODE_BIN, 32'h0000_FFFF, F_LEFT, 100, 63));
    send_request(make_request(iff_pkg::MODE_HEXL, 32'h5A5A_5A5A, F_ZERO | F_ALT, 70, -64));

    // The receiver now holds off for a long stretch while requests keep
    // coming, so the block fills up and stalls the request channel.
    hold_left = HOLD_OFF_CYCLES;

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % SEGMENT_ITEMS == 0) begin
        case ($urandom_range(0, 2))
          0: idle_odds = 0;
          1: idle_odds = 3;
          default: idle_odds = 8;
        endcase
      end
      // The final stretch runs at full rate on both sides.
      if (n >= RANDOM_ITEMS - CALM_ITEMS) idle_odds = 0;
      send_request(random_request());
    end
    req_bus.valid <= 1'b0;

    while (char_board.pending_chars.size() != 0) @(posedge clk_i);
    // Extra cycles catch any stray character after the last expected one.
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (char_board.mismatches == 0) begin
      $display("PASS integer_field_formatter_top");
    end else begin
      $display("FAIL integer_field_formatter_top");
    end
    $finish;
  end

endmodule
